@@ hw/rtl/cube_face_and_uv_select_core_macros.svh @@
// assertion macros for the cube face and coordinate select core
`ifndef CUBE_FACE_AND_UV_SELECT_CORE_MACROS_SVH
`define CUBE_FACE_AND_UV_SELECT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CFS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define CFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cfs_pkg.sv @@
// shared types and codes for the cube face and coordinate select core
`default_nettype none

package cfs_pkg;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  localparam face_t ZERO_VECTOR_FACE = FACE_NEG_X;

  typedef struct packed {
    face_t face;
    logic  zero;
    logic  sat_u;
    logic  sat_v;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/cube_face_and_uv_select_core.sv @@
// top level of the cube face and coordinate select core
// usage:
//   in_valid/in_ready carry one signed direction (in_dir_x, in_dir_y, in_dir_z)
//   out_valid/out_ready carry face index, coordinates u and v, and the
//   zero vector flag, one result per input transfer, in order
// pipeline: one select stage, one division cell per coordinate bit and one
//   output register; the cell chain divides u and v side by side
// throughput: one transfer per cycle while the skid slot is empty
// stall: with a result waiting and out_ready low, the next result goes to a
//   skid slot; while that slot is full the chain freezes and in_ready is low,
//   in_ready returns the cycle after out_ready is seen
// reset: rst_n low empties the chain and the output stage, in_ready is low
//   during reset and high right after it
// all-zero direction: face 1 (-X), both coordinates one half, flag set
`default_nettype none

module cube_face_and_uv_select_core #(
  parameter int COMPONENT_BITS = 16,
  parameter int COORD_BITS     = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire signed [COMPONENT_BITS-1:0] in_dir_x,
  input  wire signed [COMPONENT_BITS-1:0] in_dir_y,
  input  wire signed [COMPONENT_BITS-1:0] in_dir_z,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [2:0]                      out_face_index,
  output logic [COORD_BITS-1:0]           out_coord_u,
  output logic [COORD_BITS-1:0]           out_coord_v,
  output logic                            out_zero_vector
);

  localparam int B  = COMPONENT_BITS;
  localparam int CB = COORD_BITS;

  logic               en;
  logic               valid_c [0:CB];
  cfs_pkg::ctl_t      ctl_c   [0:CB];
  logic [B:0]         d2_c    [0:CB];
  logic [B:0]         ru_c    [0:CB];
  logic [B:0]         rv_c    [0:CB];
  logic [CB-1:0]      qu_c    [0:CB];
  logic [CB-1:0]      qv_c    [0:CB];

  cfs_front #(
    .COMPONENT_BITS(B)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_valid),
    .dir_x   (in_dir_x),
    .dir_y   (in_dir_y),
    .dir_z   (in_dir_z),
    .valid_o (valid_c[0]),
    .ctl_o   (ctl_c[0]),
    .d2_o    (d2_c[0]),
    .tu_o    (ru_c[0]),
    .tv_o    (rv_c[0])
  );

  assign qu_c[0] = '0;
  assign qv_c[0] = '0;

  for (genvar i = 0; i < CB; i++) begin : g_cell
    cfs_cell #(
      .COMPONENT_BITS(B),
      .COORD_BITS    (CB)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_c[i]),
      .ctl_i   (ctl_c[i]),
      .d2_i    (d2_c[i]),
      .ru_i    (ru_c[i]),
      .rv_i    (rv_c[i]),
      .qu_i    (qu_c[i]),
      .qv_i    (qv_c[i]),
      .valid_o (valid_c[i+1]),
      .ctl_o   (ctl_c[i+1]),
      .d2_o    (d2_c[i+1]),
      .ru_o    (ru_c[i+1]),
      .rv_o    (rv_c[i+1]),
      .qu_o    (qu_c[i+1]),
      .qv_o    (qv_c[i+1])
    );
  end

  cfs_out_buf #(
    .COORD_BITS(CB)
  ) u_out_buf (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (valid_c[CB]),
    .ctl_i           (ctl_c[CB]),
    .qu_i            (qu_c[CB]),
    .qv_i            (qv_c[CB]),
    .en_o            (en),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_face_index  (out_face_index),
    .out_coord_u     (out_coord_u),
    .out_coord_v     (out_coord_v),
    .out_zero_vector (out_zero_vector)
  );

  assign in_ready = en && rst_n;

endmodule

`default_nettype wire

@@ hw/rtl/cfs_front.sv @@
// major axis select and division operand setup stage
`default_nettype none

module cfs_front #(
  parameter int COMPONENT_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             en,
  input  wire                             valid_i,
  input  wire signed [COMPONENT_BITS-1:0] dir_x,
  input  wire signed [COMPONENT_BITS-1:0] dir_y,
  input  wire signed [COMPONENT_BITS-1:0] dir_z,
  output logic                            valid_o,
  output cfs_pkg::ctl_t                   ctl_o,
  output logic [COMPONENT_BITS:0]         d2_o,
  output logic [COMPONENT_BITS:0]         tu_o,
  output logic [COMPONENT_BITS:0]         tv_o
);

  localparam int B = COMPONENT_BITS;
  localparam int W = COMPONENT_BITS + 2;

  logic                  valid_r;
  cfs_pkg::ctl_t         ctl_r, ctl_nxt;
  logic [B:0]            d2_r, d2_nxt;
  logic [B:0]            tu_r, tu_nxt;
  logic [B:0]            tv_r, tv_nxt;

  logic signed [W-1:0]   xe, ye, ze, ax, ay, az;
  logic signed [W-1:0]   m, nu, nv, d, su, sv, tu, tv, d2;
  logic                  x_major, y_major, m_pos;

  always_comb begin
    xe = $signed({{2{dir_x[B-1]}}, dir_x});
    ye = $signed({{2{dir_y[B-1]}}, dir_y});
    ze = $signed({{2{dir_z[B-1]}}, dir_z});
    ax = xe[W-1] ? -xe : xe;
    ay = ye[W-1] ? -ye : ye;
    az = ze[W-1] ? -ze : ze;
    x_major = (ax >= ay) && (ax >= az);
    y_major = !x_major && (ay >= az);
    priority if (x_major) begin
      m  = xe;
      nu = -ze;
      nv = ye;
    end else if (y_major) begin
      m  = ye;
      nu = xe;
      nv = ze;
    end else begin
      m  = ze;
      nu = xe;
      nv = -ye;
    end
    m_pos = !m[W-1] && (m != '0);
    d  = m[W-1] ? -m : m;
    su = m[W-1] ? -nu : nu;
    sv = m[W-1] ? -nv : nv;
    tu = su + d;
    tv = sv + d;
    d2 = d + d;

    priority if (x_major) begin
      ctl_nxt.face = m_pos ? cfs_pkg::FACE_POS_X : cfs_pkg::FACE_NEG_X;
    end else if (y_major) begin
      ctl_nxt.face = m_pos ? cfs_pkg::FACE_POS_Y : cfs_pkg::FACE_NEG_Y;
    end else begin
      ctl_nxt.face = m_pos ? cfs_pkg::FACE_POS_Z : cfs_pkg::FACE_NEG_Z;
    end
    ctl_nxt.zero  = (d == '0);
    ctl_nxt.sat_u = (tu == d2);
    ctl_nxt.sat_v = (tv == d2);
    d2_nxt = d2[B:0];
    tu_nxt = tu[B:0];
    tv_nxt = tv[B:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_nxt;
      d2_r  <= d2_nxt;
      tu_r  <= tu_nxt;
      tv_r  <= tv_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign d2_o    = d2_r;
  assign tu_o    = tu_r;
  assign tv_o    = tv_r;

endmodule

`default_nettype wire

@@ hw/rtl/cfs_cell.sv @@
// one restoring division step producing one coordinate bit for u and v
`default_nettype none

module cfs_cell #(
  parameter int COMPONENT_BITS = 16,
  parameter int COORD_BITS     = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en,
  input  wire                         valid_i,
  input  cfs_pkg::ctl_t               ctl_i,
  input  wire  [COMPONENT_BITS:0]     d2_i,
  input  wire  [COMPONENT_BITS:0]     ru_i,
  input  wire  [COMPONENT_BITS:0]     rv_i,
  input  wire  [COORD_BITS-1:0]       qu_i,
  input  wire  [COORD_BITS-1:0]       qv_i,
  output logic                        valid_o,
  output cfs_pkg::ctl_t               ctl_o,
  output logic [COMPONENT_BITS:0]     d2_o,
  output logic [COMPONENT_BITS:0]     ru_o,
  output logic [COMPONENT_BITS:0]     rv_o,
  output logic [COORD_BITS-1:0]       qu_o,
  output logic [COORD_BITS-1:0]       qv_o
);

  localparam int B  = COMPONENT_BITS;
  localparam int CB = COORD_BITS;

  logic            valid_r;
  cfs_pkg::ctl_t   ctl_r;
  logic [B:0]      d2_r;
  logic [B:0]      ru_r, ru_nxt;
  logic [B:0]      rv_r, rv_nxt;
  logic [CB-1:0]   qu_r, qu_nxt;
  logic [CB-1:0]   qv_r, qv_nxt;

  logic [B+1:0]    ru2, rv2, dext, ru_sub, rv_sub;
  logic            ge_u, ge_v;

  always_comb begin
    ru2    = {ru_i, 1'b0};
    rv2    = {rv_i, 1'b0};
    dext   = {1'b0, d2_i};
    ge_u   = (ru2 >= dext);
    ge_v   = (rv2 >= dext);
    ru_sub = ru2 - dext;
    rv_sub = rv2 - dext;
    ru_nxt = ge_u ? ru_sub[B:0] : ru2[B:0];
    rv_nxt = ge_v ? rv_sub[B:0] : rv2[B:0];
    qu_nxt = {qu_i[CB-2:0], ge_u};
    qv_nxt = {qv_i[CB-2:0], ge_v};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r <= ctl_i;
      d2_r  <= d2_i;
      ru_r  <= ru_nxt;
      rv_r  <= rv_nxt;
      qu_r  <= qu_nxt;
      qv_r  <= qv_nxt;
    end
  end

  assign valid_o = valid_r;
  assign ctl_o   = ctl_r;
  assign d2_o    = d2_r;
  assign ru_o    = ru_r;
  assign rv_o    = rv_r;
  assign qu_o    = qu_r;
  assign qv_o    = qv_r;

endmodule

`default_nettype wire

@@ hw/rtl/cfs_out_buf.sv @@
// output register with skid slot, decouples the cell chain from out_ready
`default_nettype none

module cfs_out_buf #(
  parameter int COORD_BITS = 16
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    valid_i,
  input  cfs_pkg::ctl_t          ctl_i,
  input  wire  [COORD_BITS-1:0]  qu_i,
  input  wire  [COORD_BITS-1:0]  qv_i,
  output logic                   en_o,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [2:0]             out_face_index,
  output logic [COORD_BITS-1:0]  out_coord_u,
  output logic [COORD_BITS-1:0]  out_coord_v,
  output logic                   out_zero_vector
);

  localparam int CB = COORD_BITS;
  localparam logic [CB-1:0] HALF = {1'b1, {(CB-1){1'b0}}};

  logic            out_valid_r, out_valid_nxt;
  logic            skid_full_r, skid_full_nxt;
  logic [2:0]      face_r, skid_face_r, face_in;
  logic [CB-1:0]   u_r, skid_u_r, u_in;
  logic [CB-1:0]   v_r, skid_v_r, v_in;
  logic            zero_r, skid_zero_r;
  logic            incoming, out_free, load_out, load_skid, from_skid;

  always_comb begin
    face_in  = ctl_i.zero ? 3'(cfs_pkg::ZERO_VECTOR_FACE) : 3'(ctl_i.face);
    u_in     = ctl_i.zero ? HALF : (ctl_i.sat_u ? '1 : qu_i);
    v_in     = ctl_i.zero ? HALF : (ctl_i.sat_v ? '1 : qv_i);
    incoming = !skid_full_r && valid_i;
    out_free = !out_valid_r || out_ready;
    from_skid = out_free && skid_full_r;
    load_out  = out_free && !skid_full_r && incoming;
    load_skid = !out_free && incoming;
    out_valid_nxt = out_free ? (skid_full_r || incoming) : 1'b1;
    skid_full_nxt = out_free ? 1'b0 : (skid_full_r || incoming);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (from_skid) begin
      face_r <= skid_face_r;
      u_r    <= skid_u_r;
      v_r    <= skid_v_r;
      zero_r <= skid_zero_r;
    end else if (load_out) begin
      face_r <= face_in;
      u_r    <= u_in;
      v_r    <= v_in;
      zero_r <= ctl_i.zero;
    end
    if (load_skid) begin
      skid_face_r <= face_in;
      skid_u_r    <= u_in;
      skid_v_r    <= v_in;
      skid_zero_r <= ctl_i.zero;
    end
  end

  assign en_o            = !skid_full_r;
  assign out_valid       = out_valid_r;
  assign out_face_index  = face_r;
  assign out_coord_u     = u_r;
  assign out_coord_v     = v_r;
  assign out_zero_vector = zero_r;

endmodule

`default_nettype wire

@@ hw/rtl/cfs_checker.sv @@
// port-level checker for the cube face and coordinate select core, with bind
`default_nettype none

`include "cube_face_and_uv_select_core_macros.svh"

module cfs_checker #(
  parameter int COORD_BITS = 16
) (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [2:0]             out_face_index,
  input wire [COORD_BITS-1:0]  out_coord_u,
  input wire [COORD_BITS-1:0]  out_coord_v,
  input wire                   out_zero_vector
);

  localparam logic [COORD_BITS-1:0] HALF = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic [2:0] zero_face;

  assign zero_face = 3'(cfs_pkg::ZERO_VECTOR_FACE);

  // stalled result holds
  `CFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_face_index) && $stable(out_coord_u) && $stable(out_coord_v) && $stable(out_zero_vector), "stalled result changed")

  // zero vector result is fixed
  `CFS_ASSERT_SAME(a_zero_result, out_valid && out_zero_vector, out_face_index == zero_face && out_coord_u == HALF && out_coord_v == HALF, "bad zero vector result")

  // input side backs off only behind a stalled output
  `CFS_ASSERT_SAME(a_backpressure, !in_ready && $past(rst_n), out_valid && $past(out_valid && !out_ready), "in_ready low without output stall")

endmodule

bind cube_face_and_uv_select_core cfs_checker #(
  .COORD_BITS(COORD_BITS)
) u_cfs_checker (.*);

`default_nettype wire
